// ===== rtl/cfar2d_pkg.sv =====
// ----------------------------------------------------------------------------
// cfar2d_pkg
// Shared widths, codes and helpers for the 2-D cell-averaging CFAR detector.
// ----------------------------------------------------------------------------
`default_nettype none

package cfar2d_pkg;

    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 40;
    localparam int ROWSUM_W = 32;
    localparam int THR_W    = 48;
    localparam int ACC_W    = 44;
    localparam int SCALE_W  = 24;
    localparam int ROW_IN_W = 7;
    localparam int COL_IN_W = 8;
    localparam int CW       = 13;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    localparam logic [2:0] REG_MAP_ROWS    = 3'd0;
    localparam logic [2:0] REG_MAP_COLS    = 3'd1;
    localparam logic [2:0] REG_GUARD_CELLS = 3'd2;
    localparam logic [2:0] REG_TRAIN_CELLS = 3'd3;
    localparam logic [2:0] REG_SCALE_Q16   = 3'd4;

    function automatic t_coord clamp_coord(input t_coord v, input t_coord hi);
        t_coord res;
        res = v;
        if (v < 0) begin
            res = '0;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cfar2d_mem.sv =====
// ----------------------------------------------------------------------------
// cfar2d_mem
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cfar2d_mem #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfar2d_mul.sv =====
// ----------------------------------------------------------------------------
// cfar2d_mul
// Threshold unit: training sum times scale in two half-width products,
// then the fractional shift and saturation to the threshold width.
// ----------------------------------------------------------------------------
`default_nettype none

module cfar2d_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [cfar2d_pkg::ACC_W-1:0]    i_train,
    input  wire logic [cfar2d_pkg::SCALE_W-1:0]  i_scale,
    output logic                                 o_done,
    output logic      [cfar2d_pkg::THR_W-1:0]    o_thr
);

    import cfar2d_pkg::*;

    localparam int HALF = ACC_W / 2;
    localparam int PP_W = HALF + SCALE_W;
    localparam int FULL_W = ACC_W + SCALE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LO,
        S_HI,
        S_SUM
    } t_state;

    t_state              r_state;
    logic [ACC_W-1:0]    r_train;
    logic [SCALE_W-1:0]  r_scale;
    logic [PP_W-1:0]     r_lo;
    logic [PP_W-1:0]     r_hi;
    logic [FULL_W-1:0]   w_full;
    logic [FULL_W-1:0]   w_shift;

    assign w_full  = {r_hi, {HALF{1'b0}}} + FULL_W'(r_lo);
    assign w_shift = w_full >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_train <= i_train;
                        r_scale <= i_scale;
                        o_done  <= 1'b0;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_lo    <= r_train[HALF-1:0] * r_scale;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_hi    <= r_train[ACC_W-1:HALF] * r_scale;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (|w_shift[FULL_W-1:THR_W]) begin
                        o_thr <= '1;
                    end else begin
                        o_thr <= w_shift[THR_W-1:0];
                    end
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ca_cfar_2d_detector_top.sv =====
// ----------------------------------------------------------------------------
// ca_cfar_2d_detector_top
// A load transfer reads the table entry above as it is taken, then writes.
// A query result is registered after setup, nine reads of the single-port
// store (eight table corners and the cell power), a state for the last read,
// the multiplier and an output state that waits while the output is held.
// The next item is taken only once the block is back in idle.
// Reset (synchronous, active low) clears control and load pointer, presets config.
// ----------------------------------------------------------------------------
`default_nettype none

module ca_cfar_2d_detector_top #(
    parameter int MAX_ROWS        = 128,
    parameter int MAX_COLS        = 256,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_func,
    input  wire logic [cfar2d_pkg::SAMPLE_W-1:0]   i_power,
    input  wire logic [cfar2d_pkg::ROW_IN_W-1:0]   i_row,
    input  wire logic [cfar2d_pkg::COL_IN_W-1:0]   i_col,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [cfar2d_pkg::THR_W-1:0]      o_threshold,
    output logic                                   o_detected,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cfar2d_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [cfar2d_pkg::PDATA_W-1:0]    pwdata,
    output logic      [cfar2d_pkg::PDATA_W-1:0]    prdata,
    output logic                                   pready
);

    import cfar2d_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = SAMPLE_W + SUM_W;
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(MAX_COLS);
    localparam t_coord MAX_R = t_coord'(MAX_ROWS);
    localparam t_coord MAX_C = t_coord'(MAX_COLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_WR,
        S_Q_SET,
        S_Q_RD,
        S_Q_LAST,
        S_MUL,
        S_OUT
    } t_state;

    function automatic logic [ADDR_W-1:0] addr_of(input t_coord r, input t_coord c);
        return ADDR_W'(r) * COLS_A + ADDR_W'(c);
    endfunction

    // Configuration registers
    logic [7:0]          r_map_rows;
    logic [8:0]          r_map_cols;
    logic [2:0]          r_guard;
    logic [3:0]          r_train_cells;
    logic [SCALE_W-1:0]  r_scale;

    t_state              r_state;
    t_coord              r_load_row;
    t_coord              r_load_col;
    logic [ROWSUM_W-1:0] r_rowsum;
    t_coord              r_ld_row;
    t_coord              r_ld_col;
    logic [SAMPLE_W-1:0] r_pwr;
    t_coord              r_qr;
    t_coord              r_qc;
    t_coord              r_wra [2];
    t_coord              r_wrb [2];
    t_coord              r_wca [2];
    t_coord              r_wcb [2];
    logic [3:0]          r_k;
    logic                r_pcorner;
    logic                r_ppower;
    logic                r_pzero;
    logic                r_psub;
    logic signed [ACC_W-1:0] r_acc;
    logic [SAMPLE_W-1:0] r_cell;
    logic                r_mul_start;

    t_coord              w_rows;
    t_coord              w_cols;
    t_coord              w_nrow;
    t_coord              w_ncol;
    logic                w_in_acc;
    logic                w_cfg_wr;
    logic                w_mem_en;
    logic                w_mem_we;
    logic [ADDR_W-1:0]   w_mem_addr;
    logic [DATA_W-1:0]   w_mem_wdata;
    logic [DATA_W-1:0]   w_mem_rdata;
    logic [SUM_W-1:0]    w_above;
    logic [ROWSUM_W-1:0] w_rs;
    t_coord              w_krow;
    t_coord              w_kcol;
    logic                w_kneg;
    logic signed [ACC_W-1:0] w_val;
    logic [ACC_W-1:0]    w_train;
    logic                w_mul_done;
    logic [THR_W-1:0]    w_mul_thr;
    t_coord              w_nxt_col;
    t_coord              w_nxt_row;
    t_coord              w_d [2];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid & ~o_stall;

    always_comb begin
        unique case (paddr[4:2])
            REG_MAP_ROWS:    prdata = PDATA_W'(r_map_rows);
            REG_MAP_COLS:    prdata = PDATA_W'(r_map_cols);
            REG_GUARD_CELLS: prdata = PDATA_W'(r_guard);
            REG_TRAIN_CELLS: prdata = PDATA_W'(r_train_cells);
            REG_SCALE_Q16:   prdata = PDATA_W'(r_scale);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_rows    <= 8'd128;
            r_map_cols    <= 9'd256;
            r_guard       <= 3'd2;
            r_train_cells <= 4'd8;
            r_scale       <= SCALE_W'(2213);
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_MAP_ROWS:    r_map_rows    <= pwdata[7:0];
                REG_MAP_COLS:    r_map_cols    <= pwdata[8:0];
                REG_GUARD_CELLS: r_guard       <= pwdata[2:0];
                REG_TRAIN_CELLS: r_train_cells <= pwdata[3:0];
                REG_SCALE_Q16:   r_scale       <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective map size: zero counts as one, oversize clips to the store.
    always_comb begin
        w_rows = t_coord'(r_map_rows);
        if (r_map_rows == 8'd0) begin
            w_rows = t_coord'(1);
        end else if (w_rows > MAX_R) begin
            w_rows = MAX_R;
        end
        w_cols = t_coord'(r_map_cols);
        if (r_map_cols == 9'd0) begin
            w_cols = t_coord'(1);
        end else if (w_cols > MAX_C) begin
            w_cols = MAX_C;
        end
    end

    // Load pointer after wrapping a stale position (map size changed mid-frame).
    always_comb begin
        w_nrow = r_load_row;
        w_ncol = r_load_col;
        if (w_ncol >= w_cols) begin
            w_ncol = '0;
            w_nrow = w_nrow + t_coord'(1);
        end
        if (w_nrow >= w_rows) begin
            w_nrow = '0;
        end
    end

    // Pointer advance after the write of a load transfer.
    always_comb begin
        w_nxt_col = r_ld_col + t_coord'(1);
        w_nxt_row = r_ld_row;
        if (w_nxt_col >= w_cols) begin
            w_nxt_col = '0;
            w_nxt_row = r_ld_row + t_coord'(1);
            if (w_nxt_row >= w_rows) begin
                w_nxt_row = '0;
            end
        end
    end

    assign w_above = (r_ld_row != 0) ? w_mem_rdata[SUM_W-1:0] : '0;
    assign w_rs    = ((r_ld_col == 0) ? '0 : r_rowsum) + ROWSUM_W'(r_pwr);
    assign w_mem_wdata = {r_pwr, SUM_W'(SUM_W'(w_rs) + w_above)};

    // Corner select: bit 2 picks the window, bit 0 the row and bit 1 the column.
    always_comb begin
        if (r_k == 4'd8) begin
            w_krow = r_qr;
            w_kcol = r_qc;
        end else begin
            w_krow = r_k[0] ? r_wrb[r_k[2]] : r_wra[r_k[2]];
            w_kcol = r_k[1] ? r_wcb[r_k[2]] : r_wca[r_k[2]];
        end
        w_kneg = (w_krow < 0) || (w_kcol < 0);
    end

    always_comb begin
        w_mem_en   = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_addr = addr_of(w_krow, w_kcol);
        unique case (r_state)
            S_IDLE: begin
                w_mem_addr = addr_of(w_nrow - t_coord'(1), w_ncol);
                w_mem_en   = w_in_acc && (i_func == FUNC_LOAD) && (w_nrow != 0);
            end
            S_LD_WR: begin
                w_mem_addr = addr_of(r_ld_row, r_ld_col);
                w_mem_en   = 1'b1;
                w_mem_we   = 1'b1;
            end
            S_Q_RD: w_mem_en = 1'b1;
            default: ;
        endcase
    end

    assign w_val   = r_pzero ? '0 : ACC_W'(w_mem_rdata[SUM_W-1:0]);
    assign w_train = (r_acc <= 0) ? ACC_W'(1) : r_acc;

    assign w_d[0] = t_coord'(r_guard) + t_coord'(r_train_cells);
    assign w_d[1] = t_coord'(r_guard);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_row  <= '0;
            r_load_col  <= '0;
            r_rowsum    <= '0;
            r_pcorner   <= 1'b0;
            r_ppower    <= 1'b0;
            r_mul_start <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_pcorner   <= 1'b0;
            r_ppower    <= 1'b0;
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (r_pcorner) begin
                r_acc <= r_psub ? (r_acc - w_val) : (r_acc + w_val);
            end
            if (r_ppower) begin
                r_cell <= w_mem_rdata[DATA_W-1:SUM_W];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_func == FUNC_LOAD) begin
                            r_ld_row <= w_nrow;
                            r_ld_col <= w_ncol;
                            r_pwr    <= i_power;
                            r_state  <= S_LD_WR;
                        end else begin
                            r_qr <= clamp_coord(t_coord'(i_row), w_rows - t_coord'(1));
                            r_qc <= clamp_coord(t_coord'(i_col), w_cols - t_coord'(1));
                            r_state <= S_Q_SET;
                        end
                    end
                end
                S_LD_WR: begin
                    r_rowsum   <= w_rs;
                    r_load_row <= w_nxt_row;
                    r_load_col <= w_nxt_col;
                    r_state    <= S_IDLE;
                end
                S_Q_SET: begin
                    for (int w = 0; w < 2; w++) begin
                        r_wra[w] <= clamp_coord(r_qr + w_d[w], w_rows - t_coord'(1));
                        r_wrb[w] <= clamp_coord(r_qr - w_d[w], w_rows - t_coord'(1))
                                    - t_coord'(1);
                        r_wca[w] <= clamp_coord(r_qc + w_d[w], w_cols - t_coord'(1));
                        r_wcb[w] <= clamp_coord(r_qc - w_d[w], w_cols - t_coord'(1))
                                    - t_coord'(1);
                    end
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_state <= S_Q_RD;
                end
                S_Q_RD: begin
                    // Outer corners add with signs + - - +, inner ones the reverse.
                    r_pzero <= w_kneg;
                    r_psub  <= (r_k[0] ^ r_k[1]) ^ r_k[2];
                    if (r_k == 4'd8) begin
                        r_ppower <= 1'b1;
                        r_state  <= S_Q_LAST;
                    end else begin
                        r_pcorner <= 1'b1;
                        r_k       <= r_k + 4'd1;
                    end
                end
                S_Q_LAST: begin
                    r_mul_start <= 1'b1;
                    r_state     <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done && !r_mul_start) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid     <= 1'b1;
                        o_threshold <= w_mul_thr;
                        o_detected  <= (THR_W'(r_cell) > w_mul_thr);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    cfar2d_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    cfar2d_mul #(
        .FRAC_BITS (SCALE_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_train (w_train),
        .i_scale (r_scale),
        .o_done  (w_mul_done),
        .o_thr   (w_mul_thr)
    );

endmodule

`default_nettype wire

// ===== tb/sv/ca_cfar_2d_detector_top_tb.sv =====
// ----------------------------------------------------------------------------
// ca_cfar_2d_detector_top_tb
// Loads power maps of many sizes through the item port and queries cells.
// Each threshold and detection flag is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ca_cfar_2d_detector_top_tb;
    import cfar2d_pkg::*;

    localparam int MAX_ROWS  = 128;
    localparam int MAX_COLS  = 256;
    localparam int FRAC_BITS = 16;
    localparam int DEPTH     = MAX_ROWS * MAX_COLS;
    localparam logic [THR_W-1:0] THR_SAT = '1;

    typedef struct {
        t_func                func;
        logic [SAMPLE_W-1:0]  power;
        logic [ROW_IN_W-1:0]  row;
        logic [COL_IN_W-1:0]  col;
    } t_cell_req;

    typedef struct {
        logic [THR_W-1:0] thr;
        logic             det;
    } t_det_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_func;
    logic [SAMPLE_W-1:0]  i_power;
    logic [ROW_IN_W-1:0]  i_row;
    logic [COL_IN_W-1:0]  i_col;
    logic                 o_valid;
    logic                 i_stall;
    logic [THR_W-1:0]     o_threshold;
    logic                 o_detected;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    ca_cfar_2d_detector_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_power     (i_power),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_threshold (o_threshold),
        .o_detected  (o_detected),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    t_cell_req req_q[$];
    t_det_res  thr_q[$];

    // Predictor state.
    logic [SUM_W-1:0]    sat_tbl [DEPTH];
    logic [SAMPLE_W-1:0] pwr_mem [DEPTH];
    int                  ld_row;
    int                  ld_col;
    logic [ROWSUM_W-1:0] row_acc;
    logic [7:0]          c_rows;
    logic [8:0]          c_cols;
    logic [2:0]          c_guard;
    logic [3:0]          c_train;
    logic [SCALE_W-1:0]  c_scale;

    int        err_cnt;
    int        n_items;
    int        n_loads;
    int        n_queries;
    int        n_det;
    int        n_phases;
    int        gap_cnt;
    int        rx_wait;
    int        rx_draw;
    int        hold_left;
    bit        hold_tog;
    bit        hold_seen;
    bit        tx_idle;
    bit        rx_idle;
    logic      took;
    logic      got;
    t_cell_req nxt;
    t_det_res  want;

    always #6 i_clk = ~i_clk;

    function automatic int eff_rows();
        if (c_rows == 0) return 1;
        if (c_rows > MAX_ROWS) return MAX_ROWS;
        return int'(c_rows);
    endfunction

    function automatic int eff_cols();
        if (c_cols == 0) return 1;
        if (c_cols > MAX_COLS) return MAX_COLS;
        return int'(c_cols);
    endfunction

    function automatic int clip(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // A corner left of or above the map reads as zero.
    function automatic longint tbl_at(int r, int c);
        if (r < 0 || c < 0) return 0;
        return longint'(sat_tbl[r * MAX_COLS + c]);
    endfunction

    function automatic longint box_sum(int r1, int c1, int r2, int c2);
        if (r1 > r2 || c1 > c2) return 0;
        return tbl_at(r2, c2) - tbl_at(r1 - 1, c2) - tbl_at(r2, c1 - 1)
             + tbl_at(r1 - 1, c1 - 1);
    endfunction

    function automatic void apply_load(logic [SAMPLE_W-1:0] p);
        int rows;
        int cols;
        int idx;
        logic [SUM_W-1:0] above;
        rows = eff_rows();
        cols = eff_cols();
        if (ld_col >= cols) begin
            ld_col = 0;
            ld_row++;
        end
        if (ld_row >= rows) ld_row = 0;
        if (ld_col == 0) row_acc = '0;
        row_acc = row_acc + p;
        idx = ld_row * MAX_COLS + ld_col;
        above = (ld_row > 0) ? sat_tbl[idx - MAX_COLS] : '0;
        pwr_mem[idx] = p;
        sat_tbl[idx] = {{(SUM_W-ROWSUM_W){1'b0}}, row_acc} + above;
        ld_col++;
        if (ld_col >= cols) begin
            ld_col = 0;
            ld_row++;
            if (ld_row >= rows) ld_row = 0;
        end
    endfunction

    function automatic t_det_res score_cell(logic [ROW_IN_W-1:0] qr, logic [COL_IN_W-1:0] qc);
        int rows;
        int cols;
        int r;
        int c;
        int g;
        int h;
        longint outer;
        longint inner;
        longint diff;
        logic [63:0] train;
        logic [87:0] prod;
        t_det_res res;
        rows = eff_rows();
        cols = eff_cols();
        r = clip(int'(qr), 0, rows - 1);
        c = clip(int'(qc), 0, cols - 1);
        g = int'(c_guard);
        h = g + int'(c_train);
        outer = box_sum(clip(r - h, 0, rows - 1), clip(c - h, 0, cols - 1),
                        clip(r + h, 0, rows - 1), clip(c + h, 0, cols - 1));
        inner = box_sum(clip(r - g, 0, rows - 1), clip(c - g, 0, cols - 1),
                        clip(r + g, 0, rows - 1), clip(c + g, 0, cols - 1));
        diff = outer - inner;
        // An empty or negative training sum is raised to one LSB.
        train = (diff <= 0) ? 64'd1 : 64'(diff);
        prod = {24'b0, train} * {64'b0, c_scale};
        prod = prod >> FRAC_BITS;
        res.thr = (prod > {40'b0, THR_SAT}) ? THR_SAT : prod[THR_W-1:0];
        res.det = ({24'b0, pwr_mem[r * MAX_COLS + c]} > res.thr);
        return res;
    endfunction

    task automatic flag_err(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Input side: each transfer is predicted as it is accepted.
    always @(posedge i_clk) begin
        took <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            if (i_func == FUNC_LOAD) begin
                apply_load(i_power);
                n_loads++;
            end else begin
                want = score_cell(i_row, i_col);
                thr_q.push_back(want);
                n_queries++;
                if (want.det) n_det++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || took)) begin
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                i_valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                nxt = req_q.pop_front();
                i_func  <= nxt.func;
                i_power <= nxt.power;
                i_row   <= nxt.row;
                i_col   <= nxt.col;
                i_valid <= 1'b1;
                gap_cnt <= tx_idle ? $urandom_range(0, 13) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side: a stall count is drawn after every transfer, and a long
    // hold starts whenever the stimulus flips the hold request.
    always @(posedge i_clk) begin
        got <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (thr_q.size() == 0) begin
                flag_err($sformatf("unexpected result thr=%0h det=%0b",
                                   o_threshold, o_detected));
            end else begin
                want = thr_q.pop_front();
                if (o_threshold !== want.thr || o_detected !== want.det) begin
                    flag_err($sformatf("thr exp=%0h got=%0h, det exp=%0b got=%0b",
                                       want.thr, o_threshold, want.det, o_detected));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= 600;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (got) begin
            rx_draw = rx_idle ? $urandom_range(0, 13) : 0;
            i_stall <= (rx_draw != 0);
            rx_wait <= (rx_draw > 0) ? rx_draw - 1 : 0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic wait_drain();
        while (req_q.size() != 0 || i_valid || thr_q.size() != 0) @(posedge i_clk);
        // A load leaves no result behind, so give the block time to finish.
        repeat (24) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        logic [PDATA_W-1:0] exp_rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAP_ROWS: begin
                c_rows = val[7:0];
                exp_rd = {24'b0, c_rows};
            end
            REG_MAP_COLS: begin
                c_cols = val[8:0];
                exp_rd = {23'b0, c_cols};
            end
            REG_GUARD_CELLS: begin
                c_guard = val[2:0];
                exp_rd = {29'b0, c_guard};
            end
            REG_TRAIN_CELLS: begin
                c_train = val[3:0];
                exp_rd = {28'b0, c_train};
            end
            default: begin
                c_scale = val[SCALE_W-1:0];
                exp_rd = {8'b0, c_scale};
            end
        endcase
        @(negedge i_clk);
        psel <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== exp_rd) begin
            flag_err($sformatf("register %0d read exp=%0h got=%0h", idx, exp_rd, rd));
        end
    endtask

    task automatic push_item(t_func f, logic [SAMPLE_W-1:0] p,
                             logic [ROW_IN_W-1:0] r, logic [COL_IN_W-1:0] c);
        t_cell_req it;
        it.func  = f;
        it.power = p;
        it.row   = r;
        it.col   = c;
        req_q.push_back(it);
        n_items++;
    endtask

    task automatic set_map(int rows, int cols, int g, int t, int scale, bit idle);
        wait_drain();
        tx_idle = idle;
        rx_idle = idle;
        reg_write(REG_MAP_ROWS, rows);
        reg_write(REG_MAP_COLS, cols);
        reg_write(REG_GUARD_CELLS, g);
        reg_write(REG_TRAIN_CELLS, t);
        reg_write(REG_SCALE_Q16, scale);
        n_phases++;
    endtask

    // loads < 0 loads one whole frame.
    task automatic run_phase(int rows, int cols, int g, int t, int scale, int loads,
                             int nq, bit idle, bit hold, bit hot);
        int n;
        logic [SAMPLE_W-1:0] p;
        logic [ROW_IN_W-1:0] qr;
        logic [COL_IN_W-1:0] qc;
        set_map(rows, cols, g, t, scale, idle);
        n = (loads < 0) ? eff_rows() * eff_cols() : loads;
        for (int i = 0; i < n; i++) begin
            if (hot) begin
                p = SAMPLE_W'($urandom_range(24'hFFF000, 24'hFFFFFF));
            end else begin
                case ($urandom_range(0, 7))
                    0: p = '0;
                    1: p = '1;
                    default: p = SAMPLE_W'($urandom);
                endcase
            end
            push_item(FUNC_LOAD, p, ROW_IN_W'($urandom), COL_IN_W'($urandom));
        end
        for (int i = 0; i < nq; i++) begin
            // Halfway through, hold back until every threshold has come back.
            if (nq >= 8 && i == nq / 2) wait_drain();
            if (hold && i == 0) hold_tog <= ~hold_tog;
            if ($urandom_range(0, 1)) begin
                qr = ROW_IN_W'($urandom_range(0, eff_rows() - 1));
                qc = COL_IN_W'($urandom_range(0, eff_cols() - 1));
            end else begin
                qr = ROW_IN_W'($urandom);
                qc = COL_IN_W'($urandom);
            end
            push_item(FUNC_QUERY, SAMPLE_W'($urandom), qr, qc);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_LOAD;
        i_power = '0;
        i_row = '0;
        i_col = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        took = 1'b0;
        got = 1'b0;
        gap_cnt = 0;
        rx_wait = 0;
        hold_left = 0;
        hold_tog = 1'b0;
        hold_seen = 1'b0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        err_cnt = 0;
        n_items = 0;
        n_loads = 0;
        n_queries = 0;
        n_det = 0;
        n_phases = 0;
        ld_row = 0;
        ld_col = 0;
        row_acc = '0;
        c_rows = 8'd128;
        c_cols = 9'd256;
        c_guard = 3'd2;
        c_train = 4'd8;
        c_scale = 24'd2213;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frame: a 4x5 map with every third sample at full scale, then two
        // corners, a query well outside the map and two inner cells.
        set_map(4, 5, 0, 1, 65536, 1'b0);
        for (int i = 0; i < 20; i++) begin
            push_item(FUNC_LOAD, (i % 3 == 0) ? 24'hFFFFFF : 24'h000000, '1, '1);
        end
        push_item(FUNC_QUERY, '0, 7'd0, 8'd0);
        push_item(FUNC_QUERY, '1, 7'd3, 8'd4);
        push_item(FUNC_QUERY, '0, 7'd127, 8'd255);
        push_item(FUNC_QUERY, '1, 7'd2, 8'd2);
        push_item(FUNC_QUERY, '0, 7'd1, 8'd3);

        // Size registers out of range, window and scale extremes.
        run_phase(0, 0, 7, 15, 24'hFFFFFF, -1, 10, 1'b1, 1'b0, 1'b1);
        run_phase(255, 1, 7, 15, 24'hFFFFFF, -1, 30, 1'b1, 1'b0, 1'b1);
        run_phase(1, 511, 0, 0, 0, -1, 30, 1'b0, 1'b0, 1'b0);
        run_phase(3, 5, 0, 0, 2213, -1, 12, 1'b1, 1'b0, 1'b0);
        // A partial frame, then a smaller map that leaves the load pointer
        // past both edges, so it has to wrap to the origin.
        run_phase(6, 7, 2, 3, 9000, 26, 0, 1'b1, 1'b0, 1'b0);
        run_phase(3, 4, 1, 2, 70000, -1, 20, 1'b1, 1'b0, 1'b0);
        // Output held off long enough for the block to back up its input.
        run_phase(5, 5, 1, 2, 40000, -1, 40, 1'b0, 1'b1, 1'b0);

        while (n_items < 1300) begin
            run_phase($urandom_range(1, 12), $urandom_range(1, 16), $urandom_range(0, 7),
                      $urandom_range(0, 15),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                  : $urandom_range(500, 80000),
                      -1, $urandom_range(15, 40), $urandom_range(0, 3) != 0, 1'b0,
                      $urandom_range(0, 5) == 0);
        end

        wait_drain();
        $display("Covered %0d map settings: %0d loads and %0d queries, %0d detections.",
                 n_phases, n_loads, n_queries, n_det);
        $display("Mismatches counted: %0d.", err_cnt);
        if (err_cnt == 0 && thr_q.size() == 0) begin
            $display("ca_cfar_2d_detector_top_tb: PASS");
        end else begin
            $display("ca_cfar_2d_detector_top_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #7_200_000;
        $display("Run timed out.");
        $display("ca_cfar_2d_detector_top_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
